@@ rtl/core/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int QUO_W    = 64;
    localparam int DVS_W    = 30;
    localparam int DIV_BITS = 4;

    typedef struct packed {
        logic              vld;
        logic signed [14:0] tc;
        logic              fb;
        logic [16:0]       hq;
    } ptc_tag_t;

endpackage

@@ rtl/core/ptc_mul.sv @@
// ----------------------------------------------------------------------------
// ptc_mul
// Two-stage 64 x 64 multiplier giving the low 64 product bits.
// ----------------------------------------------------------------------------
module ptc_mul
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[31:0] * b[31:0];
            lh_reg <= 32'(a[31:0] * b[63:32]);
            hl_reg <= 32'(a[63:32] * b[31:0]);
            p_reg  <= ll_reg + {lh_reg + hl_reg, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/core/ptc_div.sv @@
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined signed-by-positive divider, truncating toward zero.
// ----------------------------------------------------------------------------
module ptc_div
    import ptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [QUO_W-1:0] num,
    input  logic [DVS_W-1:0] dvs,
    input  ptc_tag_t         tag_in,
    output logic [QUO_W-1:0] quo,
    output ptc_tag_t         tag_out
);

    localparam int NSTG = QUO_W / DIV_BITS;

    logic [QUO_W-1:0] mag_reg [0:NSTG];
    logic [DVS_W-1:0] rem_reg [0:NSTG];
    logic [DVS_W-1:0] dvs_reg [0:NSTG];
    logic             neg_reg [0:NSTG];
    ptc_tag_t         tag_reg [0:NSTG];
    logic [QUO_W-1:0] quo_reg;
    ptc_tag_t         tag_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= num[QUO_W-1];
            mag_reg[0] <= num[QUO_W-1] ? (QUO_W'(0) - num) : num;
            rem_reg[0] <= '0;
            dvs_reg[0] <= dvs;
            quo_reg    <= neg_reg[NSTG] ? (QUO_W'(0) - mag_reg[NSTG]) : mag_reg[NSTG];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0]  <= '0;
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_reg[0]  <= tag_in;
            tag_out_reg <= tag_reg[NSTG];
        end
    end

    for (genvar g = 0; g < NSTG; g++)
    begin : g_stage
        logic [DVS_W-1:0] rem_next;
        logic [QUO_W-1:0] mag_next;

        always_comb
        begin
            logic [DVS_W:0]   r;
            logic [QUO_W-1:0] m;
            r = {1'b0, rem_reg[g]};
            m = mag_reg[g];
            for (int k = 0; k < DIV_BITS; k++)
            begin
                r = {r[DVS_W-1:0], m[QUO_W-1]};
                m = {m[QUO_W-2:0], 1'b0};
                if (r >= {1'b0, dvs_reg[g]})
                begin
                    r    = r - {1'b0, dvs_reg[g]};
                    m[0] = 1'b1;
                end
            end
            rem_next = r[DVS_W-1:0];
            mag_next = m;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[g+1] <= mag_next;
                rem_reg[g+1] <= rem_next;
                dvs_reg[g+1] <= dvs_reg[g];
                neg_reg[g+1] <= neg_reg[g];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[g+1] <= '0;
            else if (en)
                tag_reg[g+1] <= tag_reg[g];
        end
    end

    assign quo     = quo_reg;
    assign tag_out = tag_out_reg;

endmodule

@@ rtl/core/pressure_temp_humidity_compensation.sv @@
// Throughput: one item per cycle; the whole pipeline holds while out_stall
// blocks a waiting result. The 64-bit quotient runs through a 16-stage
// radix-16 divider, the deepest section of the pipeline.
// Reset clears all valid bits and zeroes the coefficient registers.
// ----------------------------------------------------------------------------
// pressure_temp_humidity_compensation
// Deep pipeline applying factory compensation to raw T, P and H readings.
// ----------------------------------------------------------------------------
module pressure_temp_humidity_compensation
    import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    input  logic [15:0]        raw_humidity,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] temperature_centi,
    output logic [24:0]        pressure_q8,
    output logic [16:0]        humidity_q10,
    output logic               pressure_fallback
);

    localparam logic [2:0] CFG_TEMP    = 3'd0;
    localparam logic [2:0] CFG_PRESS_A = 3'd1;
    localparam logic [2:0] CFG_PRESS_B = 3'd2;
    localparam logic [2:0] CFG_MIXED   = 3'd3;
    localparam logic [2:0] CFG_HUM     = 3'd4;

    // configuration
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [47:0] mixed_reg;
    logic [31:0] hum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_a_reg     <= '0;
            press_b_reg     <= '0;
            mixed_reg       <= '0;
            hum_reg         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMP:    temp_coeffs_reg <= cfg_data[47:0];
                CFG_PRESS_A: press_a_reg     <= cfg_data;
                CFG_PRESS_B: press_b_reg     <= cfg_data;
                CFG_MIXED:   mixed_reg       <= cfg_data[47:0];
                CFG_HUM:     hum_reg         <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    logic [15:0]        k_t1;
    logic [15:0]        k_p1;
    logic signed [15:0] k_t2, k_t3, k_p2, k_p3, k_p4, k_p5, k_p6, k_p7, k_p8, k_p9, k_h2;
    logic [7:0]         k_h1, k_h3;
    logic signed [11:0] k_h4, k_h5;
    logic signed [7:0]  k_h6;

    assign k_t1 = temp_coeffs_reg[15:0];
    assign k_t2 = $signed(temp_coeffs_reg[31:16]);
    assign k_t3 = $signed(temp_coeffs_reg[47:32]);
    assign k_p1 = press_a_reg[15:0];
    assign k_p2 = $signed(press_a_reg[31:16]);
    assign k_p3 = $signed(press_a_reg[47:32]);
    assign k_p4 = $signed(press_a_reg[63:48]);
    assign k_p5 = $signed(press_b_reg[15:0]);
    assign k_p6 = $signed(press_b_reg[31:16]);
    assign k_p7 = $signed(press_b_reg[47:32]);
    assign k_p8 = $signed(press_b_reg[63:48]);
    assign k_p9 = $signed(mixed_reg[15:0]);
    assign k_h1 = mixed_reg[23:16];
    assign k_h2 = $signed(mixed_reg[39:24]);
    assign k_h3 = mixed_reg[47:40];
    assign k_h4 = $signed(hum_reg[11:0]);
    assign k_h5 = $signed(hum_reg[23:12]);
    assign k_h6 = $signed(hum_reg[31:24]);

    // flow control
    logic adv;
    logic out_valid_reg;

    assign adv      = ~(out_valid_reg & out_stall);
    assign in_stall = ~adv;

    logic vld_reg [1:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 16; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[1] <= in_valid;
            for (int i = 2; i <= 16; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // temperature and fine term
    logic signed [17:0] d1_next, d1_s1_reg;
    logic signed [16:0] d2_next, d2_s1_reg;
    logic signed [33:0] m1_s2_reg, m2_s2_reg;
    logic signed [22:0] at_s3_reg;
    logic signed [37:0] m3_s3_reg;
    logic signed [24:0] fine_s4_reg;
    logic signed [27:0] tcw;
    logic signed [14:0] tc_next;
    logic signed [25:0] x_s5_reg, hx_s5_reg;
    logic [19:0]        ap_reg [1:7];
    logic [15:0]        ah_reg [1:5];
    logic signed [14:0] tc_reg [5:16];

    assign d1_next = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, k_t1, 1'b0});
    assign d2_next = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, k_t1});

    always_comb
    begin
        tcw = (28'(fine_s4_reg) * 28'sd5 + 28'sd128) >>> 8;
        if (tcw < -28'sd4000)
            tc_next = -15'sd4000;
        else if (tcw > 28'sd8500)
            tc_next = 15'sd8500;
        else
            tc_next = tcw[14:0];
    end

    // pressure and humidity front end
    logic signed [51:0] xx_s6_reg;
    logic signed [41:0] xp5_s6_reg, xp2_s6_reg;
    logic signed [39:0] ha_next, ha_s6_reg;
    logic signed [33:0] hm6_s6_reg;
    logic signed [34:0] hm3_s6_reg;
    logic signed [63:0] pb_s7_reg, pa_s7_reg;
    logic signed [24:0] ha_s7_reg, ha_s8_reg, ha_s9_reg;
    logic signed [48:0] hb_s7_reg;
    logic [20:0]        p0;
    logic [63:0]        pn_s8_reg, pa_s8_reg;
    logic signed [55:0] hb_s8_reg;
    logic signed [42:0] hb_s9_reg;

    assign ha_next = (40'($signed({1'b0, ah_reg[5]})) <<< 14) - (40'(k_h4) <<< 20)
                   - 40'(hx_s5_reg) * 40'(k_h5) + 40'sd16384;
    assign p0      = 21'd1048576 - {1'b0, ap_reg[7]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_s1_reg   <= d1_next;
            d2_s1_reg   <= d2_next;
            ap_reg[1]   <= raw_pressure;
            ah_reg[1]   <= raw_humidity;
            for (int i = 2; i <= 7; i++)
                ap_reg[i] <= ap_reg[i-1];
            for (int i = 2; i <= 5; i++)
                ah_reg[i] <= ah_reg[i-1];

            m1_s2_reg   <= 34'(d1_s1_reg) * 34'(k_t2);
            m2_s2_reg   <= 34'(d2_s1_reg) * 34'(d2_s1_reg);
            at_s3_reg   <= 23'(m1_s2_reg >>> 11);
            m3_s3_reg   <= 38'(22'(m2_s2_reg >>> 12)) * 38'(k_t3);
            fine_s4_reg <= 25'(at_s3_reg) + 25'(m3_s3_reg >>> 14);

            tc_reg[5]   <= tc_next;
            for (int i = 6; i <= 16; i++)
                tc_reg[i] <= tc_reg[i-1];
            x_s5_reg    <= 26'(fine_s4_reg) - 26'sd128000;
            hx_s5_reg   <= 26'(fine_s4_reg) - 26'sd76800;

            xx_s6_reg   <= 52'(x_s5_reg) * 52'(x_s5_reg);
            xp5_s6_reg  <= 42'(x_s5_reg) * 42'(k_p5);
            xp2_s6_reg  <= 42'(x_s5_reg) * 42'(k_p2);
            ha_s6_reg   <= ha_next;
            hm6_s6_reg  <= 34'(hx_s5_reg) * 34'(k_h6);
            hm3_s6_reg  <= 35'(hx_s5_reg) * 35'($signed({1'b0, k_h3}));

            pb_s7_reg   <= 64'(68'(xx_s6_reg) * 68'(k_p6)) + (64'(xp5_s6_reg) <<< 17)
                         + (64'(k_p4) <<< 35);
            pa_s7_reg   <= (64'(68'(xx_s6_reg) * 68'(k_p3)) >>> 8) + (64'(xp2_s6_reg) <<< 12);
            ha_s7_reg   <= 25'(ha_s6_reg >>> 15);
            hb_s7_reg   <= 49'(hm6_s6_reg >>> 10) * (49'(hm3_s6_reg >>> 11) + 49'sd32768);

            pn_s8_reg   <= (64'(p0) << 31) - pb_s7_reg;
            pa_s8_reg   <= pa_s7_reg + 64'h0000_8000_0000_0000;
            ha_s8_reg   <= ha_s7_reg;
            hb_s8_reg   <= (56'(hb_s7_reg >>> 10) + 56'sd2097152) * 56'(k_h2);

            ha_s9_reg   <= ha_s8_reg;
            hb_s9_reg   <= 43'((57'(hb_s8_reg) + 57'sd8192) >>> 14);
        end
    end

    // wide products
    logic [63:0] pap_s10, num_s10, hq_s11, dd_s13, eh_s15;

    ptc_mul u_mul_pa
    (
        .clk (clk),
        .en  (adv),
        .a   (pa_s8_reg),
        .b   ({48'd0, k_p1}),
        .p   (pap_s10)
    );

    ptc_mul u_mul_num
    (
        .clk (clk),
        .en  (adv),
        .a   (pn_s8_reg),
        .b   (64'd3125),
        .p   (num_s10)
    );

    ptc_mul u_mul_hq
    (
        .clk (clk),
        .en  (adv),
        .a   (64'(ha_s9_reg)),
        .b   (64'(hb_s9_reg)),
        .p   (hq_s11)
    );

    ptc_mul u_mul_dd
    (
        .clk (clk),
        .en  (adv),
        .a   (64'($signed(hq_s11) >>> 15)),
        .b   (64'($signed(hq_s11) >>> 15)),
        .p   (dd_s13)
    );

    ptc_mul u_mul_eh
    (
        .clk (clk),
        .en  (adv),
        .a   (64'($signed(dd_s13) >>> 7)),
        .b   ({56'd0, k_h1}),
        .p   (eh_s15)
    );

    // divider staging and humidity finish
    logic [63:0]       num_reg [11:16];
    logic [DVS_W-1:0]  ad_reg  [11:16];
    logic              fb_reg  [11:16];
    logic [63:0]       hq_reg  [12:15];
    logic signed [63:0] hr;
    logic [16:0]       hf_next, hf_s16_reg;

    always_comb
    begin
        hr = $signed(hq_reg[15]) - ($signed(eh_s15) >>> 4);
        if (hr < 64'sd0)
            hf_next = '0;
        else if (hr > 64'sd419430400)
            hf_next = 17'(64'sd419430400 >>> 12);
        else
            hf_next = hr[28:12];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg[11] <= num_s10;
            ad_reg[11]  <= pap_s10[62:33];
            fb_reg[11]  <= pap_s10[63] | (pap_s10[62:33] == '0);
            for (int i = 12; i <= 16; i++)
            begin
                num_reg[i] <= num_reg[i-1];
                ad_reg[i]  <= ad_reg[i-1];
                fb_reg[i]  <= fb_reg[i-1];
            end
            hq_reg[12] <= hq_s11;
            for (int i = 13; i <= 15; i++)
                hq_reg[i] <= hq_reg[i-1];
            hf_s16_reg <= hf_next;
        end
    end

    ptc_tag_t         div_tag_in, div_tag_out;
    logic [DVS_W-1:0] div_dvs;
    logic [63:0]      quo;

    assign div_tag_in.vld = vld_reg[16];
    assign div_tag_in.tc  = tc_reg[16];
    assign div_tag_in.fb  = fb_reg[16];
    assign div_tag_in.hq  = hf_s16_reg;
    assign div_dvs        = fb_reg[16] ? DVS_W'(1) : ad_reg[16];

    ptc_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .num     (num_reg[16]),
        .dvs     (div_dvs),
        .tag_in  (div_tag_in),
        .quo     (quo),
        .tag_out (div_tag_out)
    );

    // pressure finish
    logic [63:0] ss_d2, ep_d2, c_d4;
    logic [63:0] p_reg   [1:4];
    logic [63:0] epd_reg [3:4];
    ptc_tag_t    tag_reg [1:4];

    ptc_mul u_mul_ss
    (
        .clk (clk),
        .en  (adv),
        .a   (64'($signed(quo) >>> 13)),
        .b   (64'($signed(quo) >>> 13)),
        .p   (ss_d2)
    );

    ptc_mul u_mul_ep
    (
        .clk (clk),
        .en  (adv),
        .a   (quo),
        .b   (64'(k_p8)),
        .p   (ep_d2)
    );

    ptc_mul u_mul_c
    (
        .clk (clk),
        .en  (adv),
        .a   (ss_d2),
        .b   (64'(k_p9)),
        .p   (c_d4)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[1] <= quo;
            for (int i = 2; i <= 4; i++)
                p_reg[i] <= p_reg[i-1];
            epd_reg[3] <= 64'($signed(ep_d2) >>> 19);
            epd_reg[4] <= epd_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 4; i++)
                tag_reg[i] <= '0;
        end
        else if (adv)
        begin
            tag_reg[1] <= div_tag_out;
            for (int i = 2; i <= 4; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    logic signed [63:0] psum, pfin;
    logic [24:0]        pq_next;

    always_comb
    begin
        psum = $signed(p_reg[4]) + ($signed(c_d4) >>> 25) + $signed(epd_reg[4]);
        pfin = (psum >>> 8) + (64'(k_p7) <<< 4);
        if (tag_reg[4].fb || pfin < 64'sd7680000)
            pq_next = 25'd7680000;
        else if (pfin > 64'sd28160000)
            pq_next = 25'd28160000;
        else
            pq_next = pfin[24:0];
    end

    // output register
    logic signed [14:0] tc_out_reg;
    logic [24:0]        pq_out_reg;
    logic [16:0]        hq_out_reg;
    logic               fb_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= tag_reg[4].vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tc_out_reg <= tag_reg[4].tc;
            pq_out_reg <= pq_next;
            hq_out_reg <= tag_reg[4].hq;
            fb_out_reg <= tag_reg[4].fb;
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = tc_out_reg;
    assign pressure_q8       = pq_out_reg;
    assign humidity_q10      = hq_out_reg;
    assign pressure_fallback = fb_out_reg;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the barometric compensation pipeline against an in-bench predictor.
// Coefficient sets (reset, typical, all-one, random, altered typical) are
// loaded while the pipeline is idle. Directed and random readings are then
// pushed through it with random valid and stall gaps. Each transfer out is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb;
    import ptc_pkg::*;

    localparam logic [2:0] IDX_TEMP    = 3'd0;
    localparam logic [2:0] IDX_PRESS_A = 3'd1;
    localparam logic [2:0] IDX_PRESS_B = 3'd2;
    localparam logic [2:0] IDX_MIXED   = 3'd3;
    localparam logic [2:0] IDX_HUM     = 3'd4;
    localparam logic [2:0] IDX_UNUSED  = 3'd6;

    localparam logic [47:0] TYP_TEMP    = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PRESS_A = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PRESS_B = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [47:0] TYP_MIXED   = {8'd0, 16'd362, 8'd75, 16'd6000};
    localparam logic [31:0] TYP_HUM     = {8'd30, 12'd0, 12'd324};

    typedef struct {
        logic [19:0] rt;
        logic [19:0] rp;
        logic [15:0] rh;
    } reading_t;

    typedef struct {
        logic signed [14:0] tc;
        logic [24:0]        pq;
        logic [16:0]        hq;
        logic               fb;
    } comp_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [19:0]        raw_temperature;
    logic [19:0]        raw_pressure;
    logic [15:0]        raw_humidity;
    logic               out_valid;
    logic               out_stall;
    logic signed [14:0] temperature_centi;
    logic [24:0]        pressure_q8;
    logic [16:0]        humidity_q10;
    logic               pressure_fallback;

    logic [47:0] coef_temp;
    logic [63:0] coef_press_a;
    logic [63:0] coef_press_b;
    logic [47:0] coef_mixed;
    logic [31:0] coef_hum;

    reading_t pending_readings[$];
    comp_t    expected_results[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    int       recv_hold_cycles;
    bit       send_paused;
    bit       in_taken;
    int       mismatches;
    int       transfers_in;
    int       transfers_out;
    int       fallbacks_seen;

    pressure_temp_humidity_compensation dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .raw_temperature   (raw_temperature),
        .raw_pressure      (raw_pressure),
        .raw_humidity      (raw_humidity),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .temperature_centi (temperature_centi),
        .pressure_q8       (pressure_q8),
        .humidity_q10      (humidity_q10),
        .pressure_fallback (pressure_fallback)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint signed sat(longint signed v, longint signed lo,
                                          longint signed hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic comp_t compensate(reading_t r);
        comp_t res;
        longint signed t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint signed h1, h2, h3, h4, h5, h6;
        longint signed at, ap, ah, a, b, d, x, fine, tc, p, c, e, hq;
        longint signed bit47;
        t1 = coef_temp[15:0];
        t2 = $signed(coef_temp[31:16]);
        t3 = $signed(coef_temp[47:32]);
        p1 = coef_press_a[15:0];
        p2 = $signed(coef_press_a[31:16]);
        p3 = $signed(coef_press_a[47:32]);
        p4 = $signed(coef_press_a[63:48]);
        p5 = $signed(coef_press_b[15:0]);
        p6 = $signed(coef_press_b[31:16]);
        p7 = $signed(coef_press_b[47:32]);
        p8 = $signed(coef_press_b[63:48]);
        p9 = $signed(coef_mixed[15:0]);
        h1 = coef_mixed[23:16];
        h2 = $signed(coef_mixed[39:24]);
        h3 = coef_mixed[47:40];
        h4 = $signed(coef_hum[11:0]);
        h5 = $signed(coef_hum[23:12]);
        h6 = $signed(coef_hum[31:24]);
        at = r.rt;
        ap = r.rp;
        ah = r.rh;
        bit47 = 64'sh0000_8000_0000_0000;

        d = (at >>> 3) - (t1 <<< 1);
        a = (d * t2) >>> 11;
        d = (at >>> 4) - t1;
        b = (((d * d) >>> 12) * t3) >>> 14;
        fine = a + b;
        tc = sat((fine * 5 + 128) >>> 8, -4000, 8500);

        x = fine - 128000;
        b = x * x * p6;
        b = b + ((x * p5) <<< 17);
        b = b + (p4 <<< 35);
        a = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
        a = ((bit47 + a) * p1) >>> 33;
        if (a <= 0)
        begin
            res.pq = 25'd7680000;
            res.fb = 1'b1;
        end
        else
        begin
            p = 1048576 - ap;
            p = (((p <<< 31) - b) * 3125) / a;
            c = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
            e = (p8 * p) >>> 19;
            p = ((p + c + e) >>> 8) + (p7 <<< 4);
            res.pq = sat(p, 7680000, 28160000);
            res.fb = 1'b0;
        end

        x = fine - 76800;
        a = ((ah <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
        b = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32768);
        b = ((((b >>> 10) + 2097152) * h2) + 8192) >>> 14;
        hq = a * b;
        d = hq >>> 15;
        hq = hq - ((((d * d) >>> 7) * h1) >>> 4);
        hq = sat(hq, 0, 419430400) >>> 12;

        res.tc = tc[14:0];
        res.hq = hq[16:0];
        return res;
    endfunction

    // sender: advance only after a transfer, otherwise hold the payload
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (send_paused || pending_readings.size() == 0 ||
                $urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                reading_t r;
                r = pending_readings.pop_front();
                in_valid        <= 1'b1;
                raw_temperature <= r.rt;
                raw_pressure    <= r.rp;
                raw_humidity    <= r.rh;
            end
        end
    end

    always @(negedge clk)
    begin
        if (recv_hold_cycles > 0)
        begin
            recv_hold_cycles = recv_hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            reading_t r;
            r.rt = raw_temperature;
            r.rp = raw_pressure;
            r.rh = raw_humidity;
            expected_results.push_back(compensate(r));
            transfers_in = transfers_in + 1;
            in_taken = 1'b1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            transfers_out = transfers_out + 1;
            if (expected_results.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result transfer at %0t", $realtime);
            end
            else
            begin
                comp_t w;
                w = expected_results.pop_front();
                if (w.fb)
                    fallbacks_seen = fallbacks_seen + 1;
                if (temperature_centi !== w.tc || pressure_q8 !== w.pq ||
                    humidity_q10 !== w.hq || pressure_fallback !== w.fb)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result %0d: exp t=%0d p=%0d h=%0d fb=%0b, got t=%0d p=%0d h=%0d fb=%0b",
                                 transfers_out, w.tc, w.pq, w.hq, w.fb, temperature_centi,
                                 pressure_q8, humidity_q10, pressure_fallback);
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            IDX_TEMP:    coef_temp    = val[47:0];
            IDX_PRESS_A: coef_press_a = val;
            IDX_PRESS_B: coef_press_b = val;
            IDX_MIXED:   coef_mixed   = val[47:0];
            IDX_HUM:     coef_hum     = val[31:0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_coeffs(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
                               logic [47:0] m, logic [31:0] h);
        write_reg(IDX_TEMP, {16'hFFFF, t});
        write_reg(IDX_PRESS_A, pa);
        write_reg(IDX_PRESS_B, pb);
        write_reg(IDX_MIXED, {16'hFFFF, m});
        write_reg(IDX_HUM, {32'hFFFF_FFFF, h});
        write_reg(IDX_UNUSED, {$urandom, $urandom});
    endtask

    task automatic add_reading(logic [19:0] t, logic [19:0] p, logic [15:0] h);
        reading_t r;
        r.rt = t;
        r.rp = p;
        r.rh = h;
        pending_readings.push_back(r);
    endtask

    task automatic add_random(int n);
        repeat (n)
        begin
            if ($urandom_range(3) == 0)
                add_reading($urandom, $urandom, $urandom);
            else
                add_reading(20'd519888 + $urandom_range(120000) - 60000,
                            20'd415148 + $urandom_range(300000) - 150000, $urandom);
        end
    endtask

    task automatic drain();
        while (pending_readings.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic directed_set();
        add_reading(20'd0, 20'd0, 16'd0);
        add_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        add_reading(20'd519888, 20'd415148, 16'd30000);
        add_reading(20'h80000, 20'h80000, 16'h8000);
        add_reading(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
        add_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
        add_reading(20'h55555, 20'hAAAAA, 16'h5555);
        add_reading(20'd440000, 20'd200000, 16'd65000);
        add_reading(20'd620000, 20'd700000, 16'd100);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = 3'd0;
        cfg_data         = 64'd0;
        in_valid         = 1'b0;
        raw_temperature  = 20'd0;
        raw_pressure     = 20'd0;
        raw_humidity     = 16'd0;
        out_stall        = 1'b0;
        coef_temp        = '0;
        coef_press_a     = '0;
        coef_press_b     = '0;
        coef_mixed       = '0;
        coef_hum         = '0;
        send_idle_pct    = 14;
        recv_idle_pct    = 75;
        recv_hold_cycles = 0;
        send_paused      = 1'b0;
        in_taken         = 1'b0;
        mismatches       = 0;
        transfers_in     = 0;
        transfers_out    = 0;
        fallbacks_seen   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset coefficients: divisor is zero, so pressure falls back
        directed_set();
        drain();

        load_coeffs(TYP_TEMP, TYP_PRESS_A, TYP_PRESS_B, TYP_MIXED, TYP_HUM);
        directed_set();
        add_random(180);
        drain();

        load_coeffs('1, '1, '1, '1, '1);
        directed_set();
        add_random(30);
        drain();

        send_idle_pct = 75;
        recv_idle_pct = 14;
        load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, $urandom);
        add_random(60);
        recv_hold_cycles = 300;
        send_idle_pct    = 0;
        add_random(60);
        drain();
        send_idle_pct = 75;
        load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, $urandom);
        add_random(40);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_coeffs(TYP_TEMP, TYP_PRESS_A, TYP_PRESS_B, {8'd200, TYP_MIXED[39:0]},
                    {8'hE2, 12'hFF0, 12'd324});
        add_random(60);
        while (pending_readings.size() > 30)
            @(posedge clk);
        send_paused = 1'b1;
        while (expected_results.size() != 0)
            @(posedge clk);
        send_paused = 1'b0;
        add_random(60);
        drain();

        $display("covered %0d readings in, %0d results out, %0d pressure fallbacks",
                 transfers_in, transfers_out, fallbacks_seen);
        $display("coefficient sets: reset, typical, all-one, random and altered typical");
        if (mismatches == 0)
            $display("pressure_temp_humidity_compensation: match");
        else
            $display("pressure_temp_humidity_compensation: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("pressure_temp_humidity_compensation: mismatch");
        $finish;
    end

endmodule

@@ pressure_temp_humidity_compensation.f @@
rtl/core/ptc_pkg.sv
rtl/core/ptc_mul.sv
rtl/core/ptc_div.sv
rtl/core/pressure_temp_humidity_compensation.sv
test/tb.sv
